### sv/sba_pkg.sv
`timescale 1ns / 1ps
package sba_pkg;

  localparam int NUM_CLASSES_DEF    = 16;
  localparam int MIN_SIZE_SHIFT_DEF = 5;
  localparam int PAGE_SHIFT_DEF     = 21;
  localparam int POOL_PAGES_DEF     = 64;
  localparam int HEADER_BYTES_DEF   = 64;

  localparam int SMALL_LIMIT = 512;
  localparam int OWN_W       = 5;
  localparam logic [OWN_W-1:0] OWNER_FREE = 5'd31;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_TOO_LARGE = 3'd1,
    STAT_NO_PAGE   = 3'd2,
    STAT_BAD_ADDR  = 3'd3,
    STAT_NOT_ALLOC = 3'd4
  } status_e;

  typedef struct packed {
    logic [26:0] free_address;
    logic [20:0] request_bytes;
    opcode_e     opcode;
  } req_t;

  typedef struct packed {
    logic        slab_released;
    logic [3:0]  size_class;
    status_e     status;
    logic [26:0] object_address;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_A_WALK_RD,
    ST_A_WALK_CHK,
    ST_A_FIND,
    ST_A_TAIL_RD,
    ST_A_TAIL_WR,
    ST_A_SCAN_RD,
    ST_A_SCAN_CHK,
    ST_F_RD,
    ST_F_CHK,
    ST_F_BRD,
    ST_F_BCHK,
    ST_F_WALK_RD,
    ST_F_WALK_CHK,
    ST_EMIT
  } state_e;

  // Slots in a whole page for class c.
  function automatic logic [31:0] full_cap(input int c, input int min_s, input int page_s);
    int s;
    s = min_s + c;
    if (s > page_s) return 32'd0;
    return (32'd1 << page_s) >> s;
  endfunction

  // Slots in a newly taken page; small classes keep a header and bitmap at the page end.
  function automatic logic [31:0] new_cap(input int c, input int min_s, input int page_s,
                                         input int hdr);
    int s;
    logic [31:0] pb;
    logic [31:0] used;
    s = min_s + c;
    pb = 32'd1 << page_s;
    if (s > page_s) return 32'd0;
    if ((32'd1 << s) <= 32'(SMALL_LIMIT)) begin
      used = ((pb >> s) / 8) + 32'(hdr);
      if (used >= pb) return 32'd0;
      return (pb - used) >> s;
    end
    return pb >> s;
  endfunction

endpackage

### sv/sba_stream_if.sv
`timescale 1ns / 1ps
interface sba_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/slab_bitmap_allocator.sv
`timescale 1ns / 1ps
// Slab allocator over a pool of pages with power-of-two size classes.
// The req channel carries one word per command: opcode (allocate or free),
// request_bytes and free_address. The rsp channel returns one word per
// command: object_address, status, size_class and slab_released.
// Commands are taken one at a time; req.ready is high only while the
// sequencer is idle. A finished word sits in the rsp output register, so
// the next command is accepted while the receiver stalls on it.
// An allocate walks the class list slab by slab, checks up to POOL_PAGES
// pages in turn for a free one when a new slab is needed and links it,
// and scans the bitmap one word at a time through the bitmap memory and
// the find-zero unit. A free reads the page record and bitmap word, and
// walks the list step by step when an empty slab is unlinked and returned
// to the pool. The result word is then loaded into the output register.
// Reset is synchronous and immediate: page records read as their reset
// values until first written, and a per-page high-water mark makes bitmap
// words that were never written read as all free, so no clearing pass runs.
module slab_bitmap_allocator #(
  parameter int NUM_CLASSES    = sba_pkg::NUM_CLASSES_DEF,
  parameter int MIN_SIZE_SHIFT = sba_pkg::MIN_SIZE_SHIFT_DEF,
  parameter int PAGE_SHIFT     = sba_pkg::PAGE_SHIFT_DEF,
  parameter int POOL_PAGES     = sba_pkg::POOL_PAGES_DEF,
  parameter int HEADER_BYTES   = sba_pkg::HEADER_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  sba_stream_if.sink   req,
  sba_stream_if.source rsp
);
  import sba_pkg::*;

  localparam int CNT_W = PAGE_SHIFT - MIN_SIZE_SHIFT + 1;
  localparam int WIW   = PAGE_SHIFT - MIN_SIZE_SHIFT - 6;
  localparam int HW    = WIW + 1;
  localparam int PW    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int TOT_W = CNT_W + PW;
  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int BM_AW = PW + WIW;
  localparam logic [31:0] MAX_REQ = 32'd1 << (MIN_SIZE_SHIFT + NUM_CLASSES - 1);

  typedef struct packed {
    logic [OWN_W-1:0] owner;
    logic [PW-1:0]    nxt;
    logic [CNT_W-1:0] free;
    logic [CNT_W-1:0] used;
    logic [HW-1:0]    hwm;
  } meta_t;

  function automatic meta_t reset_meta(input logic [PW-1:0] p);
    meta_t m;
    m.nxt  = p;
    m.used = '0;
    m.hwm  = '0;
    if (32'(p) < 32'(NUM_CLASSES)) begin
      m.owner = OWN_W'(p);
      m.free  = CNT_W'(full_cap(int'(p), MIN_SIZE_SHIFT, PAGE_SHIFT));
    end else begin
      m.owner = OWNER_FREE;
      m.free  = '0;
    end
    return m;
  endfunction

  // Registers
  state_e              state, state_next;
  logic                op, op_next;
  logic [20:0]         req_bytes, req_bytes_next;
  logic [26:0]         faddr, faddr_next;
  logic [CLS_W-1:0]    cls, cls_next;
  logic [PW-1:0]       pg, pg_next;
  logic [PW-1:0]       q, q_next;
  logic [PW-1:0]       prev, prev_next;
  logic [PW:0]         n, n_next;
  logic [HW-1:0]       w, w_next;
  logic [5:0]          bitn, bitn_next;
  meta_t               cur, cur_next;
  rsp_t                res, res_next;
  logic                rsp_valid, rsp_valid_next;
  rsp_t                rsp_data, rsp_data_next;
  logic [PW-1:0]       cls_tail [NUM_CLASSES];
  logic [PW-1:0]       cls_tail_next [NUM_CLASSES];
  logic [TOT_W-1:0]    cls_free [NUM_CLASSES];
  logic [TOT_W-1:0]    cls_free_next [NUM_CLASSES];
  logic                meta_vld [POOL_PAGES];
  logic                free_vec [POOL_PAGES];

  // Memory ports
  logic                m_we;
  logic [PW-1:0]       m_waddr, m_raddr, m_ra_q;
  meta_t               m_wdata;
  logic [$bits(meta_t)-1:0] m_rdata;
  logic                b_we;
  logic [BM_AW-1:0]    b_waddr, b_raddr;
  logic [63:0]         b_wdata, b_rdata;
  logic                fv_we, fv_val;
  logic [PW-1:0]       fv_addr;

  // Derived values
  meta_t               meta_rd;
  logic [63:0]         bm_view;
  logic [CNT_W-1:0]    cap, lim;
  logic [6:0]          lim7;
  logic                ffz_found;
  logic [5:0]          ffz_idx;
  logic [CLS_W-1:0]    dec_cls;
  logic [CNT_W-1:0]    newcap_c;
  logic [CNT_W-1:0]    newcap_d;
  logic [PAGE_SHIFT-1:0] f_idx;
  logic [CNT_W-1:0]    cap_rd;
  logic [26:0]         f_page_hi;
  logic [TOT_W-1:0]    cf_inc;
  logic [CNT_W+1:0]    cap_half3;
  logic [63:0]         alloc_addr;

  sba_ram #(.WIDTH($bits(meta_t)), .DEPTH(POOL_PAGES)) u_meta (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  sba_ram #(.WIDTH(64), .DEPTH(POOL_PAGES << WIW)) u_bitmap (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  sba_ffz u_ffz (.word(bm_view), .limit(lim7), .found(ffz_found), .idx(ffz_idx));

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // A page record not yet written reads as its reset value.
  assign meta_rd  = meta_vld[m_ra_q] ? meta_t'(m_rdata) : reset_meta(m_ra_q);
  // Words at or above the high-water mark were never written since the page was taken.
  assign bm_view  = (w < cur.hwm) ? b_rdata : 64'd0;
  assign cap      = cur.free + cur.used;
  assign lim      = cap - {w, 6'b0};
  assign lim7     = (lim >= CNT_W'(64)) ? 7'd64 : lim[6:0];
  assign cap_rd   = meta_rd.free + meta_rd.used;
  assign f_idx    = PAGE_SHIFT'(faddr[PAGE_SHIFT-1:0] >> (MIN_SIZE_SHIFT + int'(meta_rd.owner)));
  assign f_page_hi = faddr >> PAGE_SHIFT;
  assign newcap_c = CNT_W'(new_cap(int'(cls), MIN_SIZE_SHIFT, PAGE_SHIFT, HEADER_BYTES));
  assign newcap_d = CNT_W'(new_cap(int'(dec_cls), MIN_SIZE_SHIFT, PAGE_SHIFT, HEADER_BYTES));
  assign cf_inc   = cls_free[cls] + TOT_W'(1);
  assign cap_half3 = (({2'b0, cap} << 1) + {2'b0, cap}) >> 1;
  assign alloc_addr = (64'(pg) << PAGE_SHIFT) |
                      (64'({w[WIW-1:0], ffz_idx}) << (MIN_SIZE_SHIFT + int'(cls)));

  always_comb begin
    dec_cls = CLS_W'(NUM_CLASSES - 1);
    for (int k = NUM_CLASSES - 2; k >= 0; k--) begin
      if ((32'd1 << (MIN_SIZE_SHIFT + k)) >= 32'(req_bytes)) dec_cls = CLS_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cls_tail[c] <= PW'(c);
        cls_free[c] <= TOT_W'(full_cap(c, MIN_SIZE_SHIFT, PAGE_SHIFT));
      end
      for (int p = 0; p < POOL_PAGES; p++) begin
        meta_vld[p] <= 1'b0;
        free_vec[p] <= (p >= NUM_CLASSES);
      end
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      cls_tail  <= cls_tail_next;
      cls_free  <= cls_free_next;
      if (m_we) meta_vld[m_waddr] <= 1'b1;
      if (fv_we) free_vec[fv_addr] <= fv_val;
    end
    op        <= op_next;
    req_bytes <= req_bytes_next;
    faddr     <= faddr_next;
    cls       <= cls_next;
    pg        <= pg_next;
    q         <= q_next;
    prev      <= prev_next;
    n         <= n_next;
    w         <= w_next;
    bitn      <= bitn_next;
    cur       <= cur_next;
    res       <= res_next;
    rsp_data  <= rsp_data_next;
    m_ra_q    <= m_raddr;
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    req_bytes_next = req_bytes;
    faddr_next     = faddr;
    cls_next       = cls;
    pg_next        = pg;
    q_next         = q;
    prev_next      = prev;
    n_next         = n;
    w_next         = w;
    bitn_next      = bitn;
    cur_next       = cur;
    res_next       = res;
    rsp_data_next  = rsp_data;
    rsp_valid_next = rsp_valid && !rsp.ready;
    cls_tail_next  = cls_tail;
    cls_free_next  = cls_free;
    m_we    = 1'b0;
    m_waddr = pg;
    m_wdata = cur;
    m_raddr = '0;
    b_we    = 1'b0;
    b_waddr = {pg, w[WIW-1:0]};
    b_wdata = bm_view;
    b_raddr = {pg, w[WIW-1:0]};
    fv_we   = 1'b0;
    fv_addr = q;
    fv_val  = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          op_next        = req.data.opcode;
          req_bytes_next = req.data.request_bytes;
          faddr_next     = req.data.free_address;
          state_next     = ST_DECODE;
        end
      end

      ST_DECODE: begin
        res_next.object_address = '0;
        res_next.slab_released  = 1'b0;
        res_next.size_class     = '0;
        if (op == OP_ALLOC) begin
          if (32'(req_bytes) > MAX_REQ) begin
            res_next.status = STAT_TOO_LARGE;
            state_next      = ST_EMIT;
          end else if (newcap_d == '0) begin
            res_next.status     = STAT_TOO_LARGE;
            res_next.size_class = 4'(dec_cls);
            state_next          = ST_EMIT;
          end else begin
            res_next.size_class = 4'(dec_cls);
            cls_next = dec_cls;
            pg_next  = PW'(dec_cls);
            q_next   = '0;
            state_next = (cls_free[dec_cls] != '0) ? ST_A_WALK_RD : ST_A_FIND;
          end
        end else begin
          if (f_page_hi >= 27'(POOL_PAGES)) begin
            res_next.status = STAT_BAD_ADDR;
            state_next      = ST_EMIT;
          end else begin
            pg_next    = PW'(f_page_hi);
            state_next = ST_F_RD;
          end
        end
      end

      ST_A_WALK_RD: begin
        m_raddr    = pg;
        state_next = ST_A_WALK_CHK;
      end

      ST_A_WALK_CHK: begin
        if (meta_rd.free != '0) begin
          cur_next   = meta_rd;
          w_next     = '0;
          state_next = ST_A_SCAN_RD;
        end else if (meta_rd.nxt == PW'(cls)) begin
          q_next     = '0;
          state_next = ST_A_FIND;
        end else begin
          pg_next    = meta_rd.nxt;
          state_next = ST_A_WALK_RD;
        end
      end

      ST_A_FIND: begin
        if (free_vec[q]) begin
          cur_next.owner = OWN_W'(cls);
          cur_next.nxt   = PW'(cls);
          cur_next.free  = newcap_c;
          cur_next.used  = '0;
          cur_next.hwm   = '0;
          m_we      = 1'b1;
          m_waddr   = q;
          m_wdata   = cur_next;
          fv_we     = 1'b1;
          fv_addr   = q;
          fv_val    = 1'b0;
          pg_next   = q;
          state_next = ST_A_TAIL_RD;
        end else if (32'(q) == 32'(POOL_PAGES - 1)) begin
          res_next.status = STAT_NO_PAGE;
          state_next      = ST_EMIT;
        end else begin
          q_next = q + PW'(1);
        end
      end

      ST_A_TAIL_RD: begin
        m_raddr    = cls_tail[cls];
        state_next = ST_A_TAIL_WR;
      end

      ST_A_TAIL_WR: begin
        m_we          = 1'b1;
        m_waddr       = m_ra_q;
        m_wdata       = meta_rd;
        m_wdata.nxt   = pg;
        cls_tail_next[cls] = pg;
        cls_free_next[cls] = cls_free[cls] + TOT_W'(newcap_c);
        w_next        = '0;
        state_next    = ST_A_SCAN_RD;
      end

      ST_A_SCAN_RD: begin
        if ({w, 6'b0} >= cap) begin
          res_next.status = STAT_NO_PAGE;
          state_next      = ST_EMIT;
        end else begin
          state_next = ST_A_SCAN_CHK;
        end
      end

      ST_A_SCAN_CHK: begin
        if (ffz_found) begin
          b_we    = 1'b1;
          b_wdata = bm_view | (64'd1 << ffz_idx);
          cur_next.used = cur.used + CNT_W'(1);
          cur_next.free = cur.free - CNT_W'(1);
          if (w >= cur.hwm) cur_next.hwm = w + HW'(1);
          m_we    = 1'b1;
          m_waddr = pg;
          m_wdata = cur_next;
          cls_free_next[cls]      = cls_free[cls] - TOT_W'(1);
          res_next.status         = STAT_OK;
          res_next.object_address = alloc_addr[26:0];
          state_next              = ST_EMIT;
        end else begin
          w_next     = w + HW'(1);
          state_next = ST_A_SCAN_RD;
        end
      end

      ST_F_RD: begin
        m_raddr    = pg;
        state_next = ST_F_CHK;
      end

      ST_F_CHK: begin
        cur_next = meta_rd;
        if (32'(meta_rd.owner) >= 32'(NUM_CLASSES)) begin
          res_next.status = STAT_BAD_ADDR;
          state_next      = ST_EMIT;
        end else begin
          cls_next            = CLS_W'(meta_rd.owner);
          res_next.size_class = 4'(meta_rd.owner);
          if (32'(f_idx) >= 32'(cap_rd)) begin
            res_next.status = STAT_BAD_ADDR;
            state_next      = ST_EMIT;
          end else begin
            w_next     = HW'(f_idx >> 6);
            bitn_next  = f_idx[5:0];
            state_next = ST_F_BRD;
          end
        end
      end

      ST_F_BRD: begin
        state_next = ST_F_BCHK;
      end

      ST_F_BCHK: begin
        if (!bm_view[bitn]) begin
          res_next.status = STAT_NOT_ALLOC;
          state_next      = ST_EMIT;
        end else begin
          b_we    = 1'b1;
          b_wdata = bm_view & ~(64'd1 << bitn);
          res_next.status = STAT_OK;
          m_we    = 1'b1;
          m_waddr = pg;
          // An emptied extra slab goes back to the pool when the class, this slab
          // included, keeps at least one and a half slabs' worth of free slots.
          if (cur.used == CNT_W'(1) && pg != PW'(cls) &&
              cf_inc >= TOT_W'(cap_half3)) begin
            m_wdata.owner = OWNER_FREE;
            m_wdata.nxt   = pg;
            m_wdata.free  = '0;
            m_wdata.used  = '0;
            m_wdata.hwm   = '0;
            cls_free_next[cls] = cf_inc - TOT_W'(cap);
            fv_we     = 1'b1;
            fv_addr   = pg;
            fv_val    = 1'b1;
            res_next.slab_released = 1'b1;
            prev_next  = PW'(cls);
            n_next     = '0;
            state_next = ST_F_WALK_RD;
          end else begin
            m_wdata.used = cur.used - CNT_W'(1);
            m_wdata.free = cur.free + CNT_W'(1);
            cls_free_next[cls] = cf_inc;
            state_next = ST_EMIT;
          end
        end
      end

      ST_F_WALK_RD: begin
        m_raddr    = prev;
        state_next = ST_F_WALK_CHK;
      end

      ST_F_WALK_CHK: begin
        if (meta_rd.nxt == pg) begin
          m_we        = 1'b1;
          m_waddr     = prev;
          m_wdata     = meta_rd;
          m_wdata.nxt = cur.nxt;
          if (cls_tail[cls] == pg) cls_tail_next[cls] = prev;
          state_next  = ST_EMIT;
        end else if (n == (PW + 1)'(POOL_PAGES)) begin
          state_next = ST_EMIT;
        end else begin
          prev_next  = meta_rd.nxt;
          n_next     = n + (PW + 1)'(1);
          state_next = ST_F_WALK_RD;
        end
      end

      ST_EMIT: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_data_next  = res;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end
endmodule

### sv/sba_ram.sv
`timescale 1ns / 1ps
module sba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/sba_ffz.sv
`timescale 1ns / 1ps
module sba_ffz (
  input  logic [63:0] word,
  input  logic [6:0]  limit,
  output logic        found,
  output logic [5:0]  idx
);
  // Lowest clear bit below the limit.
  always_comb begin
    found = 1'b0;
    idx   = 6'd0;
    for (int k = 63; k >= 0; k--) begin
      if (!word[k] && (7'(k) < limit)) begin
        found = 1'b1;
        idx   = 6'(k);
      end
    end
  end
endmodule

### test/sba_alloc_checker.sv
`timescale 1ns / 1ps
module sba_alloc_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  sba_pkg::req_t  req_data,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  sba_pkg::rsp_t  rsp_data,
  output int             fails
);
  import sba_pkg::*;

  localparam int NCLS       = NUM_CLASSES_DEF;
  localparam int MIN_S      = MIN_SIZE_SHIFT_DEF;
  localparam int PG_S       = PAGE_SHIFT_DEF;
  localparam int NPAGES     = POOL_PAGES_DEF;
  localparam int WPP        = (1 << (PG_S - MIN_S)) / 64;
  localparam int BIGGEST    = 1 << (MIN_S + NCLS - 1);
  localparam int unsigned PG_BYTES = 1 << PG_S;

  logic [63:0] used_bits [0:NPAGES*WPP-1];
  logic [4:0]  pg_class  [NPAGES];
  logic [5:0]  pg_link   [NPAGES];
  int unsigned pg_avail  [NPAGES];
  int unsigned pg_taken  [NPAGES];
  logic [5:0]  cls_last  [NCLS];
  int unsigned cls_avail [NCLS];
  int unsigned cls_taken [NCLS];

  rsp_t results_due [$];

  function automatic int unsigned whole_page_slots(int c);
    return PG_BYTES >> (MIN_S + c);
  endfunction

  function automatic int unsigned fresh_slab_slots(int c);
    int s;
    int unsigned overhead;
    s = MIN_S + c;
    if (s > PG_S) return 0;
    if ((1 << s) <= SMALL_LIMIT) begin
      overhead = (PG_BYTES >> s) / 8 + HEADER_BYTES_DEF;
      if (overhead >= PG_BYTES) return 0;
      return (PG_BYTES - overhead) >> s;
    end
    return PG_BYTES >> s;
  endfunction

  task automatic clear_pool();
    for (int i = 0; i < NPAGES*WPP; i++) used_bits[i] = '0;
    for (int p = 0; p < NPAGES; p++) begin
      pg_class[p] = OWNER_FREE;
      pg_link[p]  = 6'(p);
      pg_avail[p] = 0;
      pg_taken[p] = 0;
    end
    for (int c = 0; c < NCLS; c++) begin
      pg_class[c]  = 5'(c);
      pg_avail[c]  = whole_page_slots(c);
      cls_last[c]  = 6'(c);
      cls_avail[c] = whole_page_slots(c);
      cls_taken[c] = 0;
    end
  endtask

  function automatic rsp_t allocate_slot(int unsigned nbytes);
    rsp_t r;
    int c;
    int p;
    int q;
    int unsigned cap;
    bit found;
    logic [63:0] wd;
    r = '{slab_released: 1'b0, size_class: 4'd0, status: STAT_OK, object_address: '0};
    if (nbytes > BIGGEST) begin
      r.status = STAT_TOO_LARGE;
      return r;
    end
    c = 0;
    while (c + 1 < NCLS && (1 << (MIN_S + c)) < nbytes) c++;
    r.size_class = 4'(c);
    if (fresh_slab_slots(c) == 0) begin
      r.status = STAT_TOO_LARGE;
      return r;
    end
    p = c;
    found = 0;
    if (cls_avail[c] != 0) begin
      do begin
        if (pg_avail[p] != 0) begin
          found = 1;
          break;
        end
        p = pg_link[p];
      end while (p != c);
    end
    if (!found) begin
      for (q = 0; q < NPAGES; q++) if (pg_class[q] == OWNER_FREE) break;
      if (q >= NPAGES) begin
        r.status = STAT_NO_PAGE;
        return r;
      end
      for (int i = 0; i < WPP; i++) used_bits[q*WPP + i] = '0;
      pg_class[q] = 5'(c);
      pg_avail[q] = fresh_slab_slots(c);
      pg_taken[q] = 0;
      pg_link[q]  = 6'(c);
      pg_link[cls_last[c]] = 6'(q);
      cls_last[c] = 6'(q);
      cls_avail[c] += pg_avail[q];
      p = q;
    end
    cap = pg_avail[p] + pg_taken[p];
    for (int w = 0; w * 64 < cap; w++) begin
      wd = used_bits[p*WPP + w];
      if (wd == '1) continue;
      for (int j = 0; j < 64 && w * 64 + j < cap; j++) begin
        if (!wd[j]) begin
          used_bits[p*WPP + w][j] = 1'b1;
          pg_taken[p]++;
          pg_avail[p]--;
          cls_taken[c]++;
          cls_avail[c]--;
          r.object_address = 27'((p << PG_S) + ((w * 64 + j) << (MIN_S + c)));
          return r;
        end
      end
    end
    r.status = STAT_NO_PAGE;
    return r;
  endfunction

  function automatic rsp_t release_slot(logic [26:0] addr);
    rsp_t r;
    int p;
    int c;
    int prev;
    int steps;
    int unsigned cap;
    int unsigned idx;
    r = '{slab_released: 1'b0, size_class: 4'd0, status: STAT_OK, object_address: '0};
    p = int'(addr >> PG_S);
    if (p >= NPAGES || pg_class[p] >= NCLS) begin
      r.status = STAT_BAD_ADDR;
      return r;
    end
    c = pg_class[p];
    r.size_class = 4'(c);
    cap = pg_avail[p] + pg_taken[p];
    idx = (addr & (PG_BYTES - 1)) >> (MIN_S + c);
    if (idx >= cap) begin
      r.status = STAT_BAD_ADDR;
      return r;
    end
    if (!used_bits[p*WPP + idx/64][idx%64]) begin
      r.status = STAT_NOT_ALLOC;
      return r;
    end
    used_bits[p*WPP + idx/64][idx%64] = 1'b0;
    pg_avail[p]++;
    pg_taken[p]--;
    cls_avail[c]++;
    cls_taken[c]--;
    // An emptied extra slab goes back to the pool only when the class, this
    // slab included, keeps at least one and a half slabs' worth of free slots.
    if (pg_taken[p] == 0 && p != c && cls_avail[c] >= cap * 3 / 2) begin
      prev = c;
      steps = 0;
      while (pg_link[prev] != p && steps < NPAGES) begin
        prev = pg_link[prev];
        steps++;
      end
      if (pg_link[prev] == p) begin
        pg_link[prev] = pg_link[p];
        if (cls_last[c] == p) cls_last[c] = 6'(prev);
      end
      cls_avail[c] -= cap;
      pg_class[p] = OWNER_FREE;
      pg_link[p]  = 6'(p);
      pg_avail[p] = 0;
      pg_taken[p] = 0;
      r.slab_released = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      fails = 0;
      clear_pool();
      results_due.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (results_due.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t: unexpected response word %p", $time, rsp_data);
        end else begin
          want = results_due.pop_front();
          if (rsp_data !== want) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch addr %h/%h status %0d/%0d class %0d/%0d rel %0b/%0b",
                       $time, want.object_address, rsp_data.object_address,
                       want.status, rsp_data.status, want.size_class, rsp_data.size_class,
                       want.slab_released, rsp_data.slab_released);
          end
        end
      end
      if (req_valid && req_ready) begin
        if (req_data.opcode == OP_ALLOC) results_due.push_back(allocate_slot(req_data.request_bytes));
        else results_due.push_back(release_slot(req_data.free_address));
      end
    end
  end

  function automatic int words_owed();
    return results_due.size();
  endfunction

endmodule

### test/tb_slab_bitmap_allocator.sv
`timescale 1ns / 1ps
module tb_slab_bitmap_allocator;
  import sba_pkg::*;

  typedef struct {
    logic [26:0] addr;
    logic [3:0]  cls;
  } live_obj_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails;

  sba_stream_if #(.T(req_t)) req ();
  sba_stream_if #(.T(rsp_t)) rsp ();

  slab_bitmap_allocator i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  sba_alloc_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_data  (req.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data),
    .fails     (fails)
  );

  always #2 clk = ~clk;

  live_obj_t live_objs [$];
  logic [26:0] freed_addrs [$];
  opcode_e   ops_in_flight [$];
  int  words_sent;
  int  words_back;
  int  n_ok_alloc, n_ok_free, n_released, n_errors;
  bit  quiet;
  bit  long_hold;

  // Track results to learn which addresses are live for later frees.
  always @(posedge clk) begin
    opcode_e op;
    if (!rst && rsp.valid && rsp.ready && ops_in_flight.size() != 0) begin
      op = ops_in_flight.pop_front();
      words_back++;
      if (rsp.data.status != STAT_OK) n_errors++;
      else if (op == OP_ALLOC) begin
        n_ok_alloc++;
        live_objs.push_back('{addr: rsp.data.object_address, cls: rsp.data.size_class});
      end else begin
        n_ok_free++;
        if (rsp.data.slab_released) n_released++;
      end
    end
  end

  initial begin
    int stall_left;
    rsp.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 0;
        stall_left = 400;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(opcode_e op, logic [20:0] nbytes, logic [26:0] addr);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data  <= '{free_address: addr, request_bytes: nbytes, opcode: op};
    do @(posedge clk); while (!req.ready);
    ops_in_flight.push_back(op);
    words_sent++;
  endtask

  task automatic do_alloc(logic [20:0] nbytes);
    send_word(OP_ALLOC, nbytes, 27'($urandom));
  endtask

  task automatic do_free(logic [26:0] addr);
    send_word(OP_FREE, 21'($urandom), addr);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (words_back != words_sent);
  endtask

  function automatic logic [20:0] random_size();
    int k;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return 21'($urandom_range(1048577, 2097151));
    if (pick < 73) k = $urandom_range(0, 7);
    else if (pick < 97) k = $urandom_range(8, 13);
    else k = $urandom_range(14, 15);
    if (k == 0) return 21'($urandom_range(0, 32));
    return 21'($urandom_range((32 << (k - 1)) + 1, 32 << k));
  endfunction

  task automatic random_free();
    int pick;
    int i;
    live_obj_t o;
    pick = $urandom_range(0, 99);
    if (pick < 70 && live_objs.size() != 0) begin
      i = $urandom_range(0, live_objs.size() - 1);
      o = live_objs[i];
      live_objs.delete(i);
      freed_addrs.push_back(o.addr);
      if (freed_addrs.size() > 32) void'(freed_addrs.pop_front());
      // Any offset inside the slot frees the same object.
      if ($urandom_range(0, 3) == 0) do_free(o.addr + 27'($urandom_range(0, (32 << o.cls) - 1)));
      else do_free(o.addr);
    end else if (pick < 82 && freed_addrs.size() != 0) begin
      do_free(freed_addrs[$urandom_range(0, freed_addrs.size() - 1)]);
    end else if (pick < 91) begin
      do_free(27'($urandom));
    end else begin
      do_free({6'($urandom_range(0, 63)), 21'($urandom_range(0, 2097151))});
    end
  endtask

  task automatic random_item();
    int pa;
    pa = (live_objs.size() < 20) ? 75 : (live_objs.size() > 200) ? 30 : 50;
    if ($urandom_range(0, 99) < pa) do_alloc(random_size());
    else random_free();
  endtask

  initial begin
    live_obj_t o;
    logic [26:0] a0;
    req.valid <= 1'b0;
    req.data  <= '0;
    quiet = 0;
    long_hold = 0;
    words_sent = 0;
    words_back = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Size boundaries and oversized requests.
    do_alloc(21'd0);
    do_alloc(21'd1);
    do_alloc(21'd32);
    do_alloc(21'd33);
    do_alloc(21'd512);
    do_alloc(21'd513);
    do_alloc(21'd1048576);
    do_alloc(21'd1048577);
    do_alloc(21'd2097151);
    drain();
    o = live_objs.pop_front();
    a0 = o.addr;
    do_free(a0 + 27'd5);
    do_free(a0);
    do_free(27'd40 << 21);
    do_free(27'h7ffffff);
    do_free(27'h0);
    drain();

    repeat (700) random_item();

    // Eat the whole pool with the largest class; the receiver holds off at first.
    drain();
    long_hold = 1;
    repeat (110) do_alloc(21'd1048576);
    drain();
    for (int i = live_objs.size() - 1; i >= 0; i--) begin
      if (live_objs[i].cls == 4'd15) begin
        o = live_objs[i];
        live_objs.delete(i);
        do_free(o.addr);
      end
    end
    drain();

    repeat (650) random_item();
    quiet = 1;
    repeat (150) random_item();
    drain();
    repeat (300) @(posedge clk);

    $display("Run covered %0d words: %0d allocations, %0d frees, %0d slabs released, %0d errors.",
             words_sent, n_ok_alloc, n_ok_free, n_released, n_errors);
    if (fails == 0 && i_checker.words_owed() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### slab_bitmap_allocator.f
sv/sba_pkg.sv
sv/sba_stream_if.sv
sv/sba_ram.sv
sv/sba_ffz.sv
sv/slab_bitmap_allocator.sv
test/sba_alloc_checker.sv
test/tb_slab_bitmap_allocator.sv
